>>> rtl/bau_pkg.sv
// ============================================================================
// Bounded Adam update: shared types and constants
// Transaction payloads, command and status codes, and the fixed-point
// coefficients of the optimiser.
// ============================================================================
package bau_pkg;

    // Default depth of the element stores.
    localparam int unsigned ELEMENTS_DEFAULT = 1024;

    // Command codes carried in the cmd field.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Status codes returned with each result.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Learning rate after reset, unsigned Q8.24 (about 0.001).
    localparam logic [31:0] LR_RESET = 32'd16777;

    // Q1.31 coefficients.
    localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [31:0] BETA1_Q31 = 32'd1932735283;
    localparam logic [31:0] BETA2_Q31 = 32'd2145336164;
    localparam logic [31:0] GAIN1_Q31 = 32'd214748365;
    localparam logic [31:0] GAIN2_Q31 = 32'd2147484;

    // Epsilon in Q16.32.
    localparam logic [63:0] EPS_Q32 = 64'd43;

    // Limits of the first moment, sign-extended to 64 bits.
    localparam logic [63:0] M_MAX64 = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] M_MIN64 = 64'hFFFF_8000_0000_0000;

    // Largest step magnitude, 2^40.
    localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

    // Saturation point of the clamp counter.
    localparam logic [10:0] CLAMP_MAX = 11'd2047;

    // Input transaction.
    typedef struct packed {
        logic        cmd;
        logic [9:0]  index;
        logic [31:0] gradient;
        logic [31:0] init_value;
        logic [31:0] lower_bound;
        logic [31:0] upper_bound;
        logic        last;
    } item_t;

    // Result transaction.
    typedef struct packed {
        logic [31:0] param_value;
        logic        clamped;
        logic [10:0] clamp_count;
        logic        status;
        logic        last_out;
    } result_t;

endpackage

>>> rtl/bounded_adam_update.sv
// ============================================================================
// Bounded Adam update
// Per-element Adam optimiser with box bounds, in fixed point.
// ============================================================================
// A load transaction passes from acceptance straight to the finish state. An
// update transaction runs the whole sequence: one 32x32 multiplier is reused for
// all eight products, one radix-2 divider produces the bias-corrected moments
// and the step (three quotients), and the same registers run a 48-step square
// root. An update at an index outside the stores returns after the read and
// the two beta-power products. The block takes one transaction at a time;
// item_ready is high only when it is idle, while a finished result may still
// wait in the output register.
// ============================================================================
module bounded_adam_update #(
    parameter int unsigned ELEMENTS = bau_pkg::ELEMENTS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  bau_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_ready,
    output bau_pkg::result_t result,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_data
);
    import bau_pkg::*;

    localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_PW1, S_PW2, S_T1, S_T2, S_GG, S_GB,
        S_VA, S_MH, S_VH, S_SQ, S_LR, S_ST, S_CL, S_FIN
    } state_t;

    // Element stores.
    logic [31:0] value_mem [ELEMENTS];
    logic [31:0] low_mem   [ELEMENTS];
    logic [31:0] high_mem  [ELEMENTS];
    logic [47:0] m_mem     [ELEMENTS];
    logic [63:0] v_mem     [ELEMENTS];

    logic [31:0] value_rd_reg;
    logic [31:0] low_rd_reg;
    logic [31:0] high_rd_reg;
    logic [47:0] m_rd_reg;
    logic [63:0] v_rd_reg;

    // Control state.
    state_t      state_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] lr_reg;
    logic [31:0] bp1_reg;
    logic [31:0] bp2_reg;
    logic [10:0] count_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    // Datapath registers.
    logic          cmd_reg;
    logic          last_reg;
    logic [AW-1:0] addr_reg;
    logic          in_range_reg;
    logic          g_neg_reg;
    logic [31:0]   gmag_reg;
    logic [31:0]   pw1_reg;
    logic [31:0]   pw2_reg;
    logic [31:0]   c1_reg;
    logic [31:0]   c2_reg;
    logic [63:0]   mul_p_reg;
    logic [95:0]   acc_reg;
    logic [63:0]   t1_reg;
    logic [47:0]   m_new_reg;
    logic [63:0]   tmp_reg;
    logic [63:0]   v_new_reg;
    logic [63:0]   rem_reg;
    logic [95:0]   num_reg;
    logic [63:0]   q_reg;
    logic [63:0]   d_reg;
    logic          sat_reg;
    logic [40:0]   step_reg;
    logic [31:0]   param_res_reg;
    logic          clamped_res_reg;
    logic          status_res_reg;

    // Combinational signals.
    logic          accept;
    logic          res_load;
    logic [AW+9:0] idx_wide;
    logic [AW-1:0] item_addr;
    logic          item_in_range;
    logic          load_ok;
    logic          is_mul;
    logic          is_div;
    logic [63:0]   mul_a64;
    logic [31:0]   mul_a32;
    logic [31:0]   mul_b32;
    logic [95:0]   acc_rnd96;
    logic [63:0]   rnd;
    logic [47:0]   m_mag_old;
    logic [47:0]   m_mag_new;
    logic [63:0]   t2s;
    logic [63:0]   msum;
    logic [47:0]   m_sat;
    logic [64:0]   vsum;
    logic [127:0]  div_src;
    logic [63:0]   dsel;
    logic [63:0]   div_sh;
    logic          div_ge;
    logic [63:0]   div_rem_n;
    logic [63:0]   div_q_n;
    logic [63:0]   div_result;
    logic [40:0]   step_capped;
    logic [51:0]   sq_rs;
    logic [51:0]   sq_trial;
    logic          sq_ge;
    logic [63:0]   sq_rem_n;
    logic [63:0]   sq_root_n;
    logic [42:0]   val_ext;
    logic [42:0]   low_ext;
    logic [42:0]   high_ext;
    logic [42:0]   prop;
    logic [31:0]   clamp_val;
    logic          clamp_hit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   value_wdata;
    logic [47:0]   m_wdata;
    logic [63:0]   v_wdata;

    // Handshake and input decoding.
    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A finished result moves into the output register once that is free.
    assign res_load = (state_reg == S_FIN) && (!result_valid_reg || result_ready);

    assign idx_wide      = (AW + 10)'(item.index);
    assign item_addr     = idx_wide[AW-1:0];
    assign item_in_range = (32'(item.index) < 32'(ELEMENTS));
    assign load_ok = item_in_range
                  && ($signed(item.lower_bound) <= $signed(item.upper_bound))
                  && ($signed(item.init_value) >= $signed(item.lower_bound))
                  && ($signed(item.init_value) <= $signed(item.upper_bound));

    assign is_mul = (state_reg == S_PW1) || (state_reg == S_PW2) || (state_reg == S_T1)
                 || (state_reg == S_T2) || (state_reg == S_GG) || (state_reg == S_GB)
                 || (state_reg == S_VA) || (state_reg == S_LR);
    assign is_div = (state_reg == S_MH) || (state_reg == S_VH) || (state_reg == S_ST);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a64 = '0;
        mul_b32 = '0;
        unique case (state_reg)
            S_PW1:
            begin
                mul_a64 = 64'(bp1_reg);
                mul_b32 = BETA1_Q31;
            end
            S_PW2:
            begin
                mul_a64 = 64'(bp2_reg);
                mul_b32 = BETA2_Q31;
            end
            S_T1:
            begin
                mul_a64 = 64'(m_mag_old);
                mul_b32 = BETA1_Q31;
            end
            S_T2:
            begin
                mul_a64 = 64'(gmag_reg) << 16;
                mul_b32 = GAIN1_Q31;
            end
            S_GG:
            begin
                mul_a64 = 64'(gmag_reg);
                mul_b32 = gmag_reg;
            end
            S_GB:
            begin
                mul_a64 = tmp_reg;
                mul_b32 = GAIN2_Q31;
            end
            S_VA:
            begin
                mul_a64 = v_rd_reg;
                mul_b32 = BETA2_Q31;
            end
            S_LR:
            begin
                mul_a64 = tmp_reg;
                mul_b32 = lr_reg;
            end
            default:
            begin
                mul_a64 = '0;
                mul_b32 = '0;
            end
        endcase
    end

    // The low half of the wide operand goes first, the high half second.
    assign mul_a32 = (cnt_reg == 7'd0) ? mul_a64[31:0] : mul_a64[63:32];

    // Rounding of a Q1.31 product, half away from zero on magnitudes.
    assign acc_rnd96 = acc_reg + 96'd1073741824;
    assign rnd       = acc_rnd96[94:31];

    // First moment update.
    assign m_mag_old = m_rd_reg[47] ? (48'd0 - m_rd_reg) : m_rd_reg;
    assign m_mag_new = m_new_reg[47] ? (48'd0 - m_new_reg) : m_new_reg;
    assign t2s       = g_neg_reg ? (64'd0 - rnd) : rnd;
    assign msum      = t1_reg + t2s;

    always_comb
    begin
        priority if ($signed(msum) > $signed(M_MAX64))
        begin
            m_sat = M_MAX64[47:0];
        end
        else if ($signed(msum) < $signed(M_MIN64))
        begin
            m_sat = M_MIN64[47:0];
        end
        else
        begin
            m_sat = msum[47:0];
        end
    end

    // Second moment sum, saturating at the full width.
    assign vsum = {1'b0, rnd} + {1'b0, tmp_reg};

    // Dividend and divisor selection for the shared divider.
    always_comb
    begin
        div_src = '0;
        dsel    = '0;
        unique case (state_reg)
            S_MH:
            begin
                div_src = 128'(m_mag_new) << 31;
                dsel    = 64'(c1_reg);
            end
            S_VH:
            begin
                div_src = 128'(v_new_reg) << 31;
                dsel    = 64'(c2_reg);
            end
            S_ST:
            begin
                div_src = 128'(acc_reg);
                dsel    = (64'(q_reg[47:0]) + EPS_Q32) << 8;
            end
            default:
            begin
                div_src = '0;
                dsel    = '0;
            end
        endcase
    end

    // One restoring division step per cycle.
    assign div_sh     = {rem_reg[62:0], num_reg[95]};
    assign div_ge     = rem_reg[63] || (div_sh >= d_reg);
    assign div_rem_n  = div_ge ? (div_sh - d_reg) : div_sh;
    assign div_q_n    = {q_reg[62:0], div_ge};
    assign div_result = sat_reg ? '1 : div_q_n;
    assign step_capped = (div_result > 64'(STEP_CAP)) ? STEP_CAP : div_result[40:0];

    // One square-root digit per cycle.
    assign sq_rs     = {rem_reg[49:0], num_reg[95:94]};
    assign sq_trial  = {2'b00, q_reg[47:0], 2'b01};
    assign sq_ge     = (sq_rs >= sq_trial);
    assign sq_rem_n  = 64'(sq_ge ? (sq_rs - sq_trial) : sq_rs);
    assign sq_root_n = {q_reg[62:0], sq_ge};

    // Proposal and clamp to the element's bounds.
    assign val_ext  = {{11{value_rd_reg[31]}}, value_rd_reg};
    assign low_ext  = {{11{low_rd_reg[31]}}, low_rd_reg};
    assign high_ext = {{11{high_rd_reg[31]}}, high_rd_reg};
    assign prop     = m_new_reg[47] ? (val_ext + 43'(step_reg)) : (val_ext - 43'(step_reg));

    always_comb
    begin
        priority if ($signed(prop) < $signed(low_ext))
        begin
            clamp_val = low_rd_reg;
            clamp_hit = 1'b1;
        end
        else if ($signed(prop) > $signed(high_ext))
        begin
            clamp_val = high_rd_reg;
            clamp_hit = 1'b1;
        end
        else
        begin
            clamp_val = prop[31:0];
            clamp_hit = 1'b0;
        end
    end

    // Store write port: loads in the idle state, updates at the clamp step.
    assign mem_we      = (accept && (item.cmd == CMD_LOAD) && load_ok) || (state_reg == S_CL);
    assign mem_waddr   = (state_reg == S_CL) ? addr_reg : item_addr;
    assign value_wdata = (state_reg == S_CL) ? clamp_val : item.init_value;
    assign m_wdata     = (state_reg == S_CL) ? m_new_reg : 48'd0;
    assign v_wdata     = (state_reg == S_CL) ? v_new_reg : 64'd0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_waddr] <= value_wdata;
            m_mem[mem_waddr]     <= m_wdata;
            v_mem[mem_waddr]     <= v_wdata;
        end
        if (accept && (item.cmd == CMD_LOAD) && load_ok)
        begin
            low_mem[item_addr]  <= item.lower_bound;
            high_mem[item_addr] <= item.upper_bound;
        end
        value_rd_reg <= value_mem[addr_reg];
        low_rd_reg   <= low_mem[addr_reg];
        high_rd_reg  <= high_mem[addr_reg];
        m_rd_reg     <= m_mem[addr_reg];
        v_rd_reg     <= v_mem[addr_reg];
    end

    // Sequencer, optimiser state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            lr_reg           <= LR_RESET;
            bp1_reg          <= ONE_Q31;
            bp2_reg          <= ONE_Q31;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                lr_reg <= cfg_data;
            end
            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept)
                    begin
                        if (item.cmd == CMD_LOAD)
                        begin
                            state_reg <= S_FIN;
                            if (load_ok)
                            begin
                                bp1_reg   <= ONE_Q31;
                                bp2_reg   <= ONE_Q31;
                                count_reg <= '0;
                            end
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_PW1;
                end
                S_PW1, S_PW2, S_T1, S_T2, S_GG, S_GB, S_VA, S_LR:
                begin
                    if (cnt_reg == 7'd3)
                    begin
                        cnt_reg <= '0;
                        unique case (state_reg)
                            S_PW1: state_reg <= S_PW2;
                            S_PW2: state_reg <= in_range_reg ? S_T1 : S_FIN;
                            S_T1:  state_reg <= S_T2;
                            S_T2:  state_reg <= S_GG;
                            S_GG:  state_reg <= S_GB;
                            S_GB:  state_reg <= S_VA;
                            S_VA:  state_reg <= S_MH;
                            default: state_reg <= S_ST;
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_MH, S_VH, S_ST:
                begin
                    if (cnt_reg == 7'd64)
                    begin
                        cnt_reg <= '0;
                        unique case (state_reg)
                            S_MH:    state_reg <= S_VH;
                            S_VH:    state_reg <= S_SQ;
                            default: state_reg <= S_CL;
                        endcase
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == 7'd47)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_LR;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                S_CL:
                begin
                    state_reg <= S_FIN;
                    if (clamp_hit && (count_reg < CLAMP_MAX))
                    begin
                        count_reg <= count_reg + 11'd1;
                    end
                end
                S_FIN:
                begin
                    if (res_load)
                    begin
                        result_reg.param_value <= param_res_reg;
                        result_reg.clamped     <= clamped_res_reg;
                        result_reg.clamp_count <= count_reg;
                        result_reg.status      <= status_res_reg;
                        result_reg.last_out    <= last_reg;
                        state_reg              <= S_IDLE;
                        // The last update of a pass advances the beta powers.
                        if ((cmd_reg == CMD_UPDATE) && last_reg)
                        begin
                            bp1_reg   <= pw1_reg;
                            bp2_reg   <= pw2_reg;
                            count_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Shared multiplier with a registered product.
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a32 * mul_b32;
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        // Capture the transaction.
        if (accept)
        begin
            cmd_reg         <= item.cmd;
            last_reg        <= item.last;
            addr_reg        <= item_addr;
            in_range_reg    <= item_in_range;
            g_neg_reg       <= item.gradient[31];
            gmag_reg        <= item.gradient[31] ? (32'd0 - item.gradient) : item.gradient;
            param_res_reg   <= (item.cmd == CMD_LOAD && load_ok) ? item.init_value : 32'd0;
            clamped_res_reg <= 1'b0;
            status_res_reg  <= (item.cmd == CMD_LOAD && !load_ok) ? STATUS_REJECT
                                                                   : STATUS_OK;
        end

        // Two partial products accumulate into a 96-bit product.
        if (is_mul)
        begin
            if (cnt_reg == 7'd1)
            begin
                acc_reg <= {32'd0, mul_p_reg};
            end
            else if (cnt_reg == 7'd2)
            begin
                acc_reg <= acc_reg + {mul_p_reg, 32'd0};
            end
        end

        // Results of the multiplier steps.
        if (is_mul && (cnt_reg == 7'd3))
        begin
            unique case (state_reg)
                S_PW1:
                begin
                    pw1_reg <= rnd[31:0];
                    c1_reg  <= ONE_Q31 - rnd[31:0];
                end
                S_PW2:
                begin
                    pw2_reg <= rnd[31:0];
                    c2_reg  <= ONE_Q31 - rnd[31:0];
                    if (!in_range_reg)
                    begin
                        param_res_reg   <= '0;
                        clamped_res_reg <= 1'b0;
                        status_res_reg  <= STATUS_REJECT;
                    end
                end
                S_T1:    t1_reg    <= m_rd_reg[47] ? (64'd0 - rnd) : rnd;
                S_T2:    m_new_reg <= m_sat;
                S_GG:    tmp_reg   <= acc_reg[63:0];
                S_GB:    tmp_reg   <= rnd;
                S_VA:    v_new_reg <= vsum[64] ? '1 : vsum[63:0];
                default: tmp_reg   <= tmp_reg;
            endcase
        end

        // Divider: set up on the first cycle, then one quotient bit a cycle.
        if (is_div)
        begin
            if (cnt_reg == 7'd0)
            begin
                rem_reg <= div_src[127:64];
                num_reg <= {div_src[63:0], 32'd0};
                q_reg   <= '0;
                d_reg   <= dsel;
                sat_reg <= (dsel == 64'd0) || (div_src[127:64] >= dsel);
            end
            else if ((state_reg == S_VH) && (cnt_reg == 7'd64))
            begin
                // Square root of v_hat in Q16.32 starts here.
                num_reg <= {div_result, 32'd0};
                rem_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                rem_reg <= div_rem_n;
                num_reg <= num_reg << 1;
                q_reg   <= div_q_n;
                if (cnt_reg == 7'd64)
                begin
                    unique case (state_reg)
                        S_MH:
                        begin
                            tmp_reg <= div_result;
                        end
                        default:
                        begin
                            step_reg <= step_capped;
                        end
                    endcase
                end
            end
        end

        // Square root: two radicand bits a cycle.
        if (state_reg == S_SQ)
        begin
            rem_reg <= sq_rem_n;
            num_reg <= num_reg << 2;
            q_reg   <= sq_root_n;
        end

        // Clamped proposal becomes the result.
        if (state_reg == S_CL)
        begin
            param_res_reg   <= clamp_val;
            clamped_res_reg <= clamp_hit;
            status_res_reg  <= STATUS_OK;
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Bounded Adam update regression
// Directed loads and updates at the field extremes, then random load and
// update passes checked against a fixed-point optimiser predictor, under
// several idling patterns and learning rates.
// ============================================================================
module testbench;
    import bau_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 2000;
    localparam int RANDOM_ITEMS   = 1850;

    // Idling patterns.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    logic    cfg_we;
    logic [31:0] cfg_data;

    bounded_adam_update u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Optimiser state held by the predictor.
    logic signed [31:0] pv_value [1024];
    logic signed [31:0] pv_low [1024];
    logic signed [31:0] pv_high [1024];
    logic signed [63:0] pv_m [1024];
    logic [63:0]        pv_v [1024];
    logic [31:0]        pv_b1;
    logic [31:0]        pv_b2;
    logic [10:0]        pv_clamps;
    logic [31:0]        pv_lr;
    bit                 loaded [1024];

    result_t    expected_results [$];
    idle_mode_t idle_mode;
    bit         hold_req;
    int         errors;
    int         items_sent;
    int         results_seen;
    int         clamp_results;
    int         idle_cycles;
    stim_row_t  rows [$];

    // Clock.
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Round half up of a * b / 2^31, kept to 64 bits.
    function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b} + (128'd1 << 30);
        return p[94:31];
    endfunction

    // Truncated quotient, saturating when it does not fit 64 bits.
    function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] q;
        if (d == 64'd0 || n[127:64] >= d)
            return '1;
        q = n / {64'b0, d};
        return q[63:0];
    endfunction

    // Floor of the square root of x scaled by 2^32.
    function automatic logic [63:0] sqrt_q32(input logic [63:0] x);
        logic [127:0] n;
        logic [63:0]  r;
        logic [63:0]  c;
        n = {32'b0, x, 32'b0};
        r = 64'd0;
        for (int b = 47; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'b0, c} * {64'b0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    // Works out the result of one transaction and advances the predictor state.
    function automatic result_t adam_predict(input item_t it);
        result_t            r;
        logic signed [63:0] g, m, t1, t2, prop;
        logic [63:0]        gmag, mmag, v, a, b, c1, c2, mhat, vhat, den, step;
        logic [9:0]         ix;
        r = '0;
        ix = it.index;
        r.last_out = it.last;
        if (it.cmd == CMD_LOAD)
        begin
            if ($signed(it.lower_bound) > $signed(it.upper_bound)
                || $signed(it.init_value) < $signed(it.lower_bound)
                || $signed(it.init_value) > $signed(it.upper_bound))
            begin
                r.status = STATUS_REJECT;
            end
            else
            begin
                pv_value[ix] = it.init_value;
                pv_low[ix] = it.lower_bound;
                pv_high[ix] = it.upper_bound;
                pv_m[ix] = 64'sd0;
                pv_v[ix] = 64'd0;
                pv_b1 = ONE_Q31;
                pv_b2 = ONE_Q31;
                pv_clamps = 11'd0;
                r.param_value = it.init_value;
            end
            r.clamp_count = pv_clamps;
            return r;
        end

        // First moment, rounded on magnitudes and saturated at 48 bits.
        g = 64'($signed(it.gradient));
        gmag = (g < 0) ? 64'(-g) : 64'(g);
        m = pv_m[ix];
        mmag = (m < 0) ? 64'(-m) : 64'(m);
        t1 = $signed(mul_q31(mmag, 64'(BETA1_Q31)));
        t2 = $signed(mul_q31(gmag << 16, 64'(GAIN1_Q31)));
        if (m < 0) t1 = -t1;
        if (g < 0) t2 = -t2;
        m = t1 + t2;
        if (m > $signed(M_MAX64)) m = $signed(M_MAX64);
        if (m < $signed(M_MIN64)) m = $signed(M_MIN64);
        pv_m[ix] = m;
        mmag = (m < 0) ? 64'(-m) : 64'(m);

        // Second moment, saturated at 64 bits.
        a = mul_q31(pv_v[ix], 64'(BETA2_Q31));
        b = mul_q31(gmag * gmag, 64'(GAIN2_Q31));
        v = a + b;
        if (v < a) v = '1;
        pv_v[ix] = v;

        // Bias correction and the step itself.
        c1 = 64'(ONE_Q31) - (mul_q31(64'(pv_b1), 64'(BETA1_Q31)) & 64'hFFFF_FFFF);
        c2 = 64'(ONE_Q31) - (mul_q31(64'(pv_b2), 64'(BETA2_Q31)) & 64'hFFFF_FFFF);
        mhat = div_sat({64'b0, mmag} << 31, c1 & 64'hFFFF_FFFF);
        vhat = div_sat({64'b0, v} << 31, c2 & 64'hFFFF_FFFF);
        den = (sqrt_q32(vhat) + EPS_Q32) << 8;
        step = div_sat({96'b0, pv_lr} * {64'b0, mhat}, den);
        if (step > 64'(STEP_CAP)) step = 64'(STEP_CAP);

        // Proposal, clamped to the element's bounds.
        prop = 64'(pv_value[ix]);
        prop = (m < 0) ? prop + $signed(step) : prop - $signed(step);
        if (prop < 64'(pv_low[ix]))
        begin
            prop = 64'(pv_low[ix]);
            r.clamped = 1'b1;
        end
        else if (prop > 64'(pv_high[ix]))
        begin
            prop = 64'(pv_high[ix]);
            r.clamped = 1'b1;
        end
        pv_value[ix] = prop[31:0];
        r.param_value = prop[31:0];
        r.status = STATUS_OK;
        if (r.clamped && pv_clamps < CLAMP_MAX)
            pv_clamps++;
        r.clamp_count = pv_clamps;

        // The last element of a pass closes it.
        if (it.last)
        begin
            pv_b1 = 32'(mul_q31(64'(pv_b1), 64'(BETA1_Q31)));
            pv_b2 = 32'(mul_q31(64'(pv_b2), 64'(BETA2_Q31)));
            pv_clamps = 11'd0;
        end
        return r;
    endfunction

    function automatic item_t make_item(input logic cmd, input logic [9:0] ix,
                                        input logic [31:0] g, input logic [31:0] init,
                                        input logic [31:0] lo, input logic [31:0] hi,
                                        input logic last);
        item_t it;
        it.cmd = cmd;
        it.index = ix;
        it.gradient = g;
        it.init_value = init;
        it.lower_bound = lo;
        it.upper_bound = hi;
        it.last = last;
        return it;
    endfunction

    function automatic void add_row(input item_t it, input bit typed, input result_t res);
        stim_row_t row;
        row.it = it;
        row.typed = typed;
        row.res = res;
        rows.push_back(row);
    endfunction

    // Offers one transaction and records its expected result on acceptance.
    task automatic send_item(input item_t it, input bit typed, input result_t res);
        result_t predicted;
        if ((idle_mode == IDLE_SENDER && $urandom_range(99) < 79)
            || (idle_mode == IDLE_BOTH && $urandom_range(99) < 11))
        begin
            item_valid = 1'b0;
            do
            begin
                @(negedge clk);
                idle_cycles++;
            end
            while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 79)
                   || (idle_mode == IDLE_BOTH && $urandom_range(99) < 11));
        end
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = adam_predict(it);
        if (it.cmd == CMD_LOAD && predicted.status == STATUS_OK)
            loaded[it.index] = 1'b1;
        expected_results.push_back(typed ? res : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected result has come back, then lets the block settle.
    task automatic drain;
        item_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_learning_rate(input logic [31:0] lr);
        drain();
        cfg_data = lr;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        pv_lr = lr;
    endtask

    // A random accepted load: three values sorted so the order holds.
    function automatic item_t random_load(input logic [9:0] ix, input bit narrow);
        logic signed [31:0] x [3];
        logic signed [31:0] t;
        x[0] = $urandom;
        if (narrow)
        begin
            x[1] = x[0] + $signed(32'($urandom_range(2000)));
            x[2] = x[0] + $signed(32'($urandom_range(2000)));
        end
        else
        begin
            x[1] = $urandom;
            x[2] = $urandom;
        end
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2 - i; j++)
                if (x[j] > x[j + 1])
                begin
                    t = x[j];
                    x[j] = x[j + 1];
                    x[j + 1] = t;
                end
        return make_item(CMD_LOAD, ix, $urandom, x[1], x[0], x[2], 1'($urandom_range(1)));
    endfunction

    // Gradients: mostly moderate, sometimes anywhere in the full range.
    function automatic logic [31:0] random_gradient;
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed(32'($urandom_range(262144))) - 32'sd131072);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_mode == IDLE_RECEIVER)
                result_ready = ($urandom_range(99) >= 79);
            else if (idle_mode == IDLE_BOTH)
                result_ready = ($urandom_range(99) >= 11);
            else
                result_ready = 1'b1;
        end
    end

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (result.clamped)
                clamp_results++;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation: %h", result);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.param_value !== exp_r.param_value)
                begin
                    $error("param_value expected %h got %h", exp_r.param_value,
                           result.param_value);
                    errors++;
                end
                if (result.clamped !== exp_r.clamped)
                begin
                    $error("clamped expected %b got %b", exp_r.clamped, result.clamped);
                    errors++;
                end
                if (result.clamp_count !== exp_r.clamp_count)
                begin
                    $error("clamp_count expected %0d got %0d", exp_r.clamp_count,
                           result.clamp_count);
                    errors++;
                end
                if (result.status !== exp_r.status)
                begin
                    $error("status expected %b got %b", exp_r.status, result.status);
                    errors++;
                end
                if (result.last_out !== exp_r.last_out)
                begin
                    $error("last_out expected %b got %b", exp_r.last_out, result.last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("bounded_adam_update regression: fail");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        result_t     ok_r;
        logic [9:0]  elems [$];
        logic [9:0]  ix;
        int          session;
        int          n_elems;
        int          n_passes;
        logic [31:0] lr_choices [5];

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        hold_req = 1'b0;
        idle_mode = IDLE_NONE;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        clamp_results = 0;
        idle_cycles = 0;
        for (int i = 0; i < 1024; i++)
        begin
            pv_value[i] = '0;
            pv_low[i] = '0;
            pv_high[i] = '0;
            pv_m[i] = '0;
            pv_v[i] = '0;
            loaded[i] = 1'b0;
        end
        pv_b1 = ONE_Q31;
        pv_b2 = ONE_Q31;
        pv_clamps = '0;
        pv_lr = LR_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: extremes, rejected loads, equal and narrow bounds.
        ok_r = '0;
        add_row(make_item(CMD_LOAD, 10'd0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000, 1'b0),
                1'b1, '{32'h0, 1'b0, 11'd0, STATUS_OK, 1'b0});
        add_row(make_item(CMD_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 1'b1),
                1'b1, '{32'h7FFF_FFFF, 1'b0, 11'd0, STATUS_OK, 1'b1});
        add_row(make_item(CMD_LOAD, 10'd5, 32'h0, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 1'b0),
                1'b1, '{32'h8000_0000, 1'b0, 11'd0, STATUS_OK, 1'b0});
        add_row(make_item(CMD_LOAD, 10'd2, 32'h0, 32'h0, 32'h0000_0010, 32'h0000_0001, 1'b0),
                1'b1, '{32'h0, 1'b0, 11'd0, STATUS_REJECT, 1'b0});
        add_row(make_item(CMD_LOAD, 10'd3, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b1),
                1'b1, '{32'h0, 1'b0, 11'd0, STATUS_REJECT, 1'b1});
        add_row(make_item(CMD_LOAD, 10'd4, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFE, 1'b0),
                1'b1, '{32'h0, 1'b0, 11'd0, STATUS_REJECT, 1'b0});
        add_row(make_item(CMD_LOAD, 10'd7, 32'h0, 32'd100, 32'd0, 32'd200, 1'b0),
                1'b1, '{32'd100, 1'b0, 11'd0, STATUS_OK, 1'b0});
        add_row(make_item(CMD_UPDATE, 10'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd1023, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd5, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd7, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd0, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd7, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd1023, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1),
                1'b0, ok_r);
        add_row(make_item(CMD_UPDATE, 10'd5, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1),
                1'b0, ok_r);
        foreach (rows[i])
            send_item(rows[i].it, rows[i].typed, rows[i].res);

        // Directed learning-rate extremes, zero among them.
        lr_choices[0] = 32'hFFFF_FFFF;
        lr_choices[1] = 32'd1;
        lr_choices[2] = 32'd0;
        lr_choices[3] = LR_RESET;
        lr_choices[4] = 32'h0100_0000;
        for (int k = 0; k < 3; k++)
        begin
            write_learning_rate(lr_choices[k]);
            send_item(make_item(CMD_UPDATE, 10'd0, 32'h0001_0000, $urandom, $urandom,
                                $urandom, 1'b0), 1'b0, ok_r);
            send_item(make_item(CMD_UPDATE, 10'd7, 32'hFFFF_0000, $urandom, $urandom,
                                $urandom, 1'b1), 1'b0, ok_r);
        end

        // Random sessions: loads of a small set, then passes of updates.
        session = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_mode = idle_mode_t'(session % 4);
            if (session % 3 == 0)
                write_learning_rate((session % 6 == 0) ? $urandom
                                                        : lr_choices[$urandom_range(4)]);
            if (session == 5)
                hold_req = 1'b1;
            elems.delete();
            n_elems = $urandom_range(6, 1);
            for (int e = 0; e < n_elems; e++)
            begin
                ix = 10'($urandom);
                elems.push_back(ix);
                send_item(random_load(ix, 1'($urandom_range(1))), 1'b0, ok_r);
                // Occasional load with its order broken.
                if ($urandom_range(9) == 0)
                    send_item(make_item(CMD_LOAD, 10'($urandom), $urandom, 32'h0000_0100,
                                        32'h0000_0200, 32'h0000_0300,
                                        1'($urandom_range(1))),
                              1'b0, ok_r);
            end
            n_passes = $urandom_range(8, 1);
            for (int p = 0; p < n_passes; p++)
                for (int e = 0; e < elems.size(); e++)
                    send_item(make_item(CMD_UPDATE, elems[e], random_gradient(), $urandom,
                                        $urandom, $urandom,
                                        (e == elems.size() - 1) && ($urandom_range(7) != 0)),
                              1'b0, ok_r);
            // Now and then a stray update of some element loaded earlier.
            if ($urandom_range(3) == 0)
            begin
                ix = 10'($urandom);
                if (loaded[ix])
                    send_item(make_item(CMD_UPDATE, ix, random_gradient(), $urandom,
                                        $urandom, $urandom, 1'($urandom_range(1))),
                              1'b0, ok_r);
            end
            // Sender pause until every expected result is back.
            if (session % 5 == 2)
                drain();
            session++;
        end

        drain();
        repeat (300) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        $display("Covered %0d transactions in %0d sessions, %0d clamped results,",
                 items_sent, session, clamp_results);
        $display("with learning rates from zero to full scale and %0d sender idle cycles.",
                 idle_cycles);
        if (errors == 0)
            $display("bounded_adam_update regression: pass");
        else
            $display("bounded_adam_update regression: fail");
        $finish;
    end

endmodule
